// File: sv/dq_pkg.sv
// Shared types, constants and a helper function for the double-ended queue.
package dq_pkg;

  // Ring size and stored word width.
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 64;

  // Width of the interface word fields.
  localparam int unsigned FIELD_BITS = 64;

  // Slot index and entry count widths.
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef logic [FIELD_BITS-1:0] field_word_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Request codes. Code 7 is unused and acts as a no-op.
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Input beat.
  typedef struct packed {
    logic [2:0]  req_type;
    field_word_t data_word;
  } req_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]  status;
    field_word_t result_word;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // apply the request on the input port
    logic capture;  // load the output register from the RAM read data
    logic take;     // the output beat is taken this cycle
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;   // output register holds a beat
    logic needs_read;  // the pending request returns a stored word
  } dq_sts_t;

  // (a + b) modulo DEPTH, for a < DEPTH and b <= DEPTH.
  function automatic idx_t ring_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: sv/double_ended_queue_core.sv
// Top level of the double-ended queue: controller, datapath and port wiring.
//
//   Channel | Direction | Handshake                 | Beat
//   in      | input     | in_valid_i / in_ready_o   | in_req_i  (req_type, data_word)
//   out     | output    | out_valid_o / out_ready_i | out_rsp_o (status, result_word)
//
// Push, clear, no-op and error requests load their result when accepted; they can follow
// back to back while each result is taken. A successful pop or peek passes through the read
// state: the entry RAM read port is registered, and that state loads the output register.
// Reset empties the queue and clears the output valid flag; stored words are not cleared.
// A new request is taken while a result waits only if that result is taken in the same cycle.
module double_ended_queue_core import dq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  // Handshake and sequencing.
  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Ring pointers, storage and result register.
  dq_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_rsp_o(out_rsp_o)
  );

  assign out_valid_o = sts.out_valid;

endmodule

// File: sv/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dq_datapath.sv
// Datapath of the double-ended queue: ring pointers, entry RAM and output register.
module dq_datapath import dq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    in_req_i,
  input  dq_cmd_t cmd_i,
  output dq_sts_t sts_o,
  output rsp_t    out_rsp_o
);

  localparam idx_t LAST_IDX = IDX_W'(DEPTH - 1);
  localparam cnt_t FULL_CNT = CNT_W'(DEPTH);

  idx_t  front_q, front_d;
  cnt_t  count_q, count_d;
  logic  out_valid_q, out_valid_d;
  rsp_t  rsp_q, rsp_d;

  logic  is_empty, is_full;
  idx_t  front_prev, back_idx;
  logic  ram_we, ram_re;
  idx_t  ram_waddr, ram_raddr;
  word_t ram_rdata;
  logic  needs_read;
  logic [1:0] imm_status;

  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q >= FULL_CNT);
  assign front_prev = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign back_idx   = ring_add(front_q, count_q - 1'b1);

  // Decode the request against the current fill level.
  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = front_prev;
    ram_raddr  = front_q;
    needs_read = 1'b0;
    imm_status = ST_OK;
    case (in_req_i.req_type)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          imm_status = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = front_prev;
          front_d   = front_prev;
          count_d   = count_q + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (is_full) begin
          imm_status = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ring_add(front_q, count_q);
          count_d   = count_q + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          imm_status = ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = front_q;
          needs_read = 1'b1;
          front_d    = ring_add(front_q, CNT_W'(1));
          count_d    = count_q - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (is_empty) begin
          imm_status = ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = back_idx;
          needs_read = 1'b1;
          count_d    = count_q - 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (is_empty) begin
          imm_status = ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = front_q;
          needs_read = 1'b1;
        end
      end
      REQ_PEEK_BACK: begin
        if (is_empty) begin
          imm_status = ST_EMPTY;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = back_idx;
          needs_read = 1'b1;
        end
      end
      REQ_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
        // Unused code: no operation, status ok.
      end
    endcase
  end

  // Entry storage.
  dq_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept & ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_req_i.data_word[WORD_BITS-1:0]),
    .re_i   (cmd_i.accept & ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.accept) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Output register: immediate results load on accept, read results when the controller signals capture.
  always_comb begin
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    if (cmd_i.capture) begin
      out_valid_d       = 1'b1;
      rsp_d.status      = ST_OK;
      rsp_d.result_word = field_word_t'(ram_rdata);
    end else if (cmd_i.accept && !needs_read) begin
      out_valid_d       = 1'b1;
      rsp_d.status      = imm_status;
      rsp_d.result_word = '0;
    end else if (cmd_i.take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign sts_o.out_valid  = out_valid_q;
  assign sts_o.needs_read = needs_read;
  assign out_rsp_o        = rsp_q;

  // The fill level never passes the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("entry count exceeds ring depth");

  // A clear leaves an empty ring starting at slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && in_req_i.req_type == REQ_CLEAR) |=> (count_q == '0 && front_q == '0))
    else $error("clear did not reset the ring pointers");

  // Read data is only captured into an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.capture |-> !out_valid_q)
    else $error("captured read data over a pending output beat");

endmodule

// File: sv/dq_ctrl.sv
// Controller of the double-ended queue: request handshake and read sequencing.
module dq_ctrl import dq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  input  dq_sts_t sts_i,
  output dq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Take a request when idle and the output register is free by the next edge.
  assign in_ready_o = (state_q == S_IDLE) && (!sts_i.out_valid || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.accept  = accept;
  assign cmd_o.capture = (state_q == S_READ);
  assign cmd_o.take    = sts_i.out_valid && out_ready_i;

  // Next state: a successful pop or peek moves to the read state to wait for the RAM read data.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.needs_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A read request always moves to the capture cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.needs_read) |=> (state_q == S_READ))
    else $error("read request did not enter the capture cycle");

  // The capture cycle lasts exactly one clock.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_IDLE))
    else $error("capture cycle did not return to idle");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the double-ended queue core with a predicting scoreboard.
`timescale 1ns / 100ps

module testbench;
  import dq_pkg::*;

  // Request code 7 has no operation behind it.
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int unsigned ITEMS_PER_PHASE = 450;

  // Mirrors the queue contents and holds the responses still owed by the core.
  class deque_checker;
    word_t       slots[DEPTH];
    int unsigned head;
    int unsigned fill;
    rsp_t        owed[$];
    int unsigned errors;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] deque check failed: %s", $time, what);
      errors++;
    endtask

    // Applies one request to the mirror and returns the response it should give.
    function rsp_t response_for(req_t r);
      rsp_t        rsp;
      word_t       w;
      int unsigned tail;
      rsp.status = ST_OK;
      rsp.result_word = '0;
      w = r.data_word[WORD_BITS-1:0];
      tail = (head + fill + DEPTH - 1) % DEPTH;
      case (r.req_type)
        REQ_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            head = (head == 0) ? DEPTH - 1 : head - 1;
            slots[head] = w;
            fill++;
          end
        end
        REQ_PUSH_BACK: begin
          if (fill == DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            slots[(head + fill) % DEPTH] = w;
            fill++;
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
          if (fill == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.result_word = field_word_t'(slots[head]);
            if (r.req_type == REQ_POP_FRONT) begin
              head = (head + 1) % DEPTH;
              fill--;
            end
          end
        end
        REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (fill == 0) begin
            rsp.status = ST_EMPTY;
          end else begin
            rsp.result_word = field_word_t'(slots[tail]);
            if (r.req_type == REQ_POP_BACK) begin
              fill--;
            end
          end
        end
        REQ_CLEAR: begin
          head = 0;
          fill = 0;
        end
        default: begin
        end
      endcase
      return rsp;
    endfunction

    function void note_request(req_t r);
      owed.push_back(response_for(r));
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("response %p arrived with nothing owed", got));
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      end
      if (got.result_word !== want.result_word) begin
        report_mismatch($sformatf("word %h, wanted %h", got.result_word, want.result_word));
      end
    endtask

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  deque_checker board;

  double_ended_queue_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Receiver back-pressure, decided once per cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && board != null) begin
      if (out_valid && out_ready) begin
        board.check_response(out_rsp);
      end
      if (in_valid && in_ready) begin
        board.note_request(in_req);
      end
    end
  end

  // Presents one beat and holds it until the core takes it.
  task drive_beat(logic [2:0] op, field_word_t word);
    @(negedge clk);
    in_valid <= 1'b1;
    in_req <= '{req_type: op, data_word: word};
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Random idle cycles on the input side between beats.
  task sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk);
      end
    end
  endtask

  task send(logic [2:0] op, field_word_t word);
    drive_beat(op, word);
    sender_gap();
  endtask

  function automatic field_word_t any_word();
    return {$urandom, $urandom};
  endfunction

  // Walks the empty and full boundaries with fixed patterns.
  task run_directed();
    send(REQ_POP_FRONT, any_word());
    send(REQ_PEEK_BACK, any_word());
    send(REQ_UNUSED, '1);
    send(REQ_PUSH_FRONT, '1);
    send(REQ_PUSH_BACK, '0);
    // Alternate ends so the front index wraps below zero.
    for (int i = 0; i < 14; i++) begin
      send((i % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
           (i % 2 == 0) ? {32{2'b10}} : {32{2'b01}});
    end
    send(REQ_PUSH_FRONT, any_word());
    send(REQ_PUSH_BACK, any_word());
    send(REQ_PEEK_FRONT, '0);
    send(REQ_PEEK_BACK, '0);
    send(REQ_POP_BACK, '1);
    send(REQ_POP_FRONT, '1);
    send(REQ_CLEAR, any_word());
    send(REQ_POP_BACK, any_word());
    send(REQ_PEEK_FRONT, any_word());
  endtask

  // Random requests that lean toward filling or draining in turns.
  task run_random(int unsigned count);
    int unsigned lean_left;
    bit          filling;
    int unsigned pick;
    logic [2:0]  op;
    lean_left = 0;
    filling = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      if (lean_left == 0) begin
        filling = !filling;
        lean_left = $urandom_range(60, 20);
      end
      lean_left--;
      pick = $urandom_range(99);
      if (pick < 1) begin
        op = REQ_CLEAR;
      end else if (pick < 3) begin
        op = REQ_UNUSED;
      end else if (pick < (filling ? 70 : 30)) begin
        op = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else begin
        case ($urandom_range(3))
          0: op = REQ_POP_FRONT;
          1: op = REQ_POP_BACK;
          2: op = REQ_PEEK_FRONT;
          default: op = REQ_PEEK_BACK;
        endcase
      end
      send(op, any_word());
    end
  endtask

  // Main sequence: reset, directed beats, four random phases with different idle and stall settings, drain and verdict.
  initial begin
    int unsigned waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 56;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 56;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    run_random(ITEMS_PER_PHASE);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (board.pending() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (board.pending() > 0) begin
      board.report_mismatch($sformatf("%0d responses never arrived", board.pending()));
    end
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop in case the core hangs.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/dq_datapath.sv
sv/dq_ctrl.sv
sv/double_ended_queue_core.sv
tb/testbench.sv
